// ===== rtl/pmcd_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet click decoder.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package pmcd_pkg;

  localparam int MaxEvents = 6;
  localparam int EvIdxW    = $clog2(MaxEvents);
  localparam int EvCntW    = $clog2(MaxEvents + 1);
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [1:0] CfgWidth    = 2'd0;
  localparam logic [1:0] CfgHeight   = 2'd1;
  localparam logic [1:0] CfgInterval = 2'd2;

  localparam logic [15:0] ResetWidth    = 16'd800;
  localparam logic [15:0] ResetHeight   = 16'd600;
  localparam logic [15:0] ResetInterval = 16'd20;
  localparam logic [15:0] ResetCursorX  = 16'd400;
  localparam logic [15:0] ResetCursorY  = 16'd300;

  localparam logic [3:0] MsgLeftDown     = 4'd0;
  localparam logic [3:0] MsgLeftUp       = 4'd1;
  localparam logic [3:0] MsgLeftDouble   = 4'd2;
  localparam logic [3:0] MsgRightDown    = 4'd3;
  localparam logic [3:0] MsgRightUp      = 4'd4;
  localparam logic [3:0] MsgRightDouble  = 4'd5;
  localparam logic [3:0] MsgMiddleDown   = 4'd6;
  localparam logic [3:0] MsgMiddleUp     = 4'd7;
  localparam logic [3:0] MsgMiddleDouble = 4'd8;
  localparam logic [3:0] MsgMove         = 4'd9;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic [30:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  msg_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  msg_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } event_t;

  typedef struct packed {
    logic [EvCntW-1:0]            count;
    event_t [MaxEvents-1:0]       ev;
  } bundle_t;

  typedef struct packed {
    logic [15:0] disp_width;
    logic [15:0] disp_height;
    logic [15:0] click_interval;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/pmcd_front.sv =====
// Front part: accepts items, frames PS/2 packets, moves the cursor and runs the
// click machines, producing at most one bundle of events per item. Depends on pmcd_pkg.
`default_nettype none

module pmcd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire pmcd_pkg::in_item_t item,
  input  wire pmcd_pkg::cfg_t     cfg,
  output logic                    bundle_push,
  output pmcd_pkg::bundle_t       bundle
);
  import pmcd_pkg::*;

  typedef enum logic [3:0] {
    PhAck = 4'b0001,
    PhHdr = 4'b0010,
    PhX   = 4'b0100,
    PhY   = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    RsArmed = 4'b0001,
    RsOne   = 4'b0010,
    RsTwo   = 4'b0100,
    RsOff   = 4'b1000
  } resync_t;

  typedef enum logic [3:0] {
    CsIdle  = 4'b0001,
    CsFdown = 4'b0010,
    CsFup   = 4'b0100,
    CsSdown = 4'b1000
  } click_t;

  localparam logic [7:0] AckByte    = 8'hFA;
  localparam logic [7:0] ResyncByte = 8'h0C;

  phase_t      phase_r, phase_nxt;
  resync_t     resync_r, resync_nxt;
  logic        xsign_r, xsign_nxt;
  logic        ysign_r, ysign_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [5:0]  edge_r, edge_nxt;
  logic [15:0] cur_x_r, cur_x_nxt;
  logic [15:0] cur_y_r, cur_y_nxt;
  click_t      click_r [3];
  click_t      click_nxt [3];
  logic [15:0] press_x_r [3];
  logic [15:0] press_x_nxt [3];
  logic [15:0] press_y_r [3];
  logic [15:0] press_y_nxt [3];
  logic [30:0] press_tick_r [3];
  logic [30:0] press_tick_nxt [3];
  logic [2:0]  expired;
  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;

  function automatic logic [15:0] clamp_pos(input logic signed [17:0] v,
                                            input logic [15:0] size);
    logic [15:0] res;
    begin
      if (v < 0) begin
        res = '0;
      end else if (v[16:0] >= {1'b0, size}) begin
        res = (size == '0) ? '0 : size - 16'd1;
      end else begin
        res = v[15:0];
      end
      return res;
    end
  endfunction

  function automatic logic [3:0] down_code(input logic [1:0] b);
    logic [3:0] c;
    begin
      case (b)
        2'd0:    c = MsgLeftDown;
        2'd1:    c = MsgRightDown;
        default: c = MsgMiddleDown;
      endcase
      return c;
    end
  endfunction

  function automatic logic [3:0] up_code(input logic [1:0] b);
    logic [3:0] c;
    begin
      case (b)
        2'd0:    c = MsgLeftUp;
        2'd1:    c = MsgRightUp;
        default: c = MsgMiddleUp;
      endcase
      return c;
    end
  endfunction

  function automatic logic [3:0] double_code(input logic [1:0] b);
    logic [3:0] c;
    begin
      case (b)
        2'd0:    c = MsgLeftDouble;
        2'd1:    c = MsgRightDouble;
        default: c = MsgMiddleDouble;
      endcase
      return c;
    end
  endfunction

  assign sum_x = $signed({2'b00, cur_x_r}) + $signed({{10{xsign_r}}, item.data_byte});
  assign sum_y = $signed({2'b00, cur_y_r}) - $signed({{10{ysign_r}}, item.data_byte});

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      expired[b] = ({1'b0, press_tick_r[b]} + {16'b0, cfg.click_interval})
                   <= {1'b0, item.now_tick};
    end
  end

  always_comb begin
    logic [EvCntW-1:0] n;
    logic              done;
    click_t            cs;
    phase_nxt  = phase_r;
    resync_nxt = resync_r;
    xsign_nxt  = xsign_r;
    ysign_nxt  = ysign_r;
    held_nxt   = held_r;
    edge_nxt   = edge_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    for (int b = 0; b < 3; b++) begin
      click_nxt[b]      = click_r[b];
      press_x_nxt[b]    = press_x_r[b];
      press_y_nxt[b]    = press_y_r[b];
      press_tick_nxt[b] = press_tick_r[b];
    end
    bundle = '0;
    n      = '0;
    done   = 1'b0;
    cs     = CsIdle;
    if (accept) begin
      if (item.cmd) begin
        for (int b = 0; b < 3; b++) begin
          if ((click_r[b] == CsFdown || click_r[b] == CsFup) && expired[b]) begin
            bundle.ev[EvIdxW'(n)] = {down_code(2'(b)), press_x_r[b], press_y_r[b]};
            n = n + EvCntW'(1);
            if (click_r[b] == CsFup) begin
              bundle.ev[EvIdxW'(n)] = {up_code(2'(b)), press_x_r[b], press_y_r[b]};
              n = n + EvCntW'(1);
            end
            click_nxt[b] = CsIdle;
          end
        end
      end else begin
        if (resync_r == RsArmed && item.data_byte == 8'h00) begin
          resync_nxt = RsOne;
        end else if (resync_r == RsOne && item.data_byte == 8'h00) begin
          resync_nxt = RsTwo;
        end else if (item.data_byte == ResyncByte) begin
          resync_nxt = RsArmed;
        end else begin
          resync_nxt = RsOff;
        end

        case (phase_r)
          PhAck: begin
            if (item.data_byte == AckByte) begin
              phase_nxt = PhHdr;
            end
          end
          PhHdr: begin
            if (item.data_byte[3]) begin
              for (int b = 0; b < 3; b++) begin
                if (item.data_byte[b]) begin
                  if (held_r[b]) begin
                    edge_nxt[2*b] = 1'b0;
                  end else begin
                    edge_nxt[2*b] = 1'b1;
                    held_nxt[b]   = 1'b1;
                  end
                end else begin
                  if (!held_r[b]) begin
                    edge_nxt[2*b+1] = 1'b0;
                  end else begin
                    edge_nxt[2*b+1] = 1'b1;
                    held_nxt[b]     = 1'b0;
                  end
                end
              end
              xsign_nxt = item.data_byte[4];
              ysign_nxt = item.data_byte[5];
              phase_nxt = PhX;
            end
          end
          PhX: begin
            cur_x_nxt = clamp_pos(sum_x, cfg.disp_width);
            phase_nxt = PhY;
          end
          PhY: begin
            cur_y_nxt = clamp_pos(sum_y, cfg.disp_height);
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PhHdr;
          end
        endcase

        if (phase_r != PhAck) begin
          if (resync_nxt == RsTwo) begin
            phase_nxt  = PhHdr;
            resync_nxt = RsOff;
          end else if (done) begin
            phase_nxt = PhHdr;
            for (int b = 0; b < 3; b++) begin
              cs = click_r[b];
              if (edge_r[2*b]) begin
                if (cs == CsIdle) begin
                  cs                = CsFdown;
                  press_x_nxt[b]    = cur_x_nxt;
                  press_y_nxt[b]    = cur_y_nxt;
                  press_tick_nxt[b] = item.now_tick;
                end else if (cs == CsFup) begin
                  cs = CsSdown;
                  bundle.ev[EvIdxW'(n)] = {double_code(2'(b)), cur_x_nxt, cur_y_nxt};
                  n = n + EvCntW'(1);
                end
              end
              if (edge_r[2*b+1]) begin
                if (cs == CsIdle) begin
                  bundle.ev[EvIdxW'(n)] = {up_code(2'(b)), cur_x_nxt, cur_y_nxt};
                  n = n + EvCntW'(1);
                end else if (cs == CsFdown) begin
                  cs = CsFup;
                end else if (cs == CsSdown) begin
                  cs = CsIdle;
                end
              end
              click_nxt[b] = cs;
            end
            if (edge_r == '0) begin
              bundle.ev[EvIdxW'(n)] = {MsgMove, cur_x_nxt, cur_y_nxt};
              n = n + EvCntW'(1);
            end
            edge_nxt = '0;
          end
        end
      end
    end
    bundle.count = n;
    bundle_push  = accept && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PhAck;
      resync_r <= RsArmed;
      xsign_r  <= 1'b0;
      ysign_r  <= 1'b0;
      held_r   <= '0;
      edge_r   <= '0;
      cur_x_r  <= ResetCursorX;
      cur_y_r  <= ResetCursorY;
      for (int b = 0; b < 3; b++) begin
        click_r[b] <= CsIdle;
      end
    end else begin
      phase_r  <= phase_nxt;
      resync_r <= resync_nxt;
      xsign_r  <= xsign_nxt;
      ysign_r  <= ysign_nxt;
      held_r   <= held_nxt;
      edge_r   <= edge_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      for (int b = 0; b < 3; b++) begin
        click_r[b] <= click_nxt[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 3; b++) begin
      press_x_r[b]    <= press_x_nxt[b];
      press_y_r[b]    <= press_y_nxt[b];
      press_tick_r[b] <= press_tick_nxt[b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmcd_queue.sv =====
// Short queue of event bundles between the front and the back part.
// Depends on pmcd_pkg for the bundle type and the depth.
`default_nettype none

module pmcd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire pmcd_pkg::bundle_t  wr_data,
  input  wire logic               pop,
  output pmcd_pkg::bundle_t       head,
  output pmcd_pkg::q_status_t     status
);
  import pmcd_pkg::*;

  bundle_t          mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    begin
      if (p == QPtrW'(QDepth - 1)) begin
        r = '0;
      end else begin
        r = p + QPtrW'(1);
      end
      return r;
    end
  endfunction

  assign status.full  = (cnt_r == QCntW'(QDepth));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmcd_back.sv =====
// Back part: walks the head bundle one event per cycle, while the receiver keeps up, into the output register.
// Depends on pmcd_pkg for the bundle and result types.
`default_nettype none

module pmcd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pmcd_pkg::bundle_t   head,
  input  wire pmcd_pkg::q_status_t qstat,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output pmcd_pkg::out_item_t      out_item
);
  import pmcd_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [EvIdxW-1:0] idx_r, idx_nxt;
  logic              load;
  logic              is_last;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign load     = !qstat.empty && (!out_valid_r || pop);
  assign is_last  = ({1'b0, idx_r} + 4'(1)) == 4'(head.count);
  assign q_pop    = load && is_last;

  always_comb begin
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_nxt       = {head.ev[idx_r], is_last};
      idx_nxt       = is_last ? '0 : idx_r + EvIdxW'(1);
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_click_decoder_unit.sv =====
// Top level of the PS/2 mouse packet click decoder: configuration registers,
// front part, bundle queue and back part. Depends on pmcd_pkg and all pmcd_ modules.
//
// Items enter through push/full/in_item; each is a mouse byte or a timer check.
// An item is taken on any cycle with push high and full low, one per cycle.
// All of an item's work is done in the cycle it is taken; any events (up to six)
// are written as one bundle into a two-entry queue.
// Results leave through empty/pop/out_item, one event per cycle while the receiver
// keeps popping. An item's events are registered first in the queue and then in
// the output register before they reach the result ports, and last marks an
// item's final event.
// full rises only while both queue entries hold bundles, so a stalled receiver
// backs up the output register, then the queue, then the input.
// Configuration is written with cfg_we, cfg_index and cfg_data;
// index 0 is screen width, 1 screen height, 2 click interval.
// Reset restores width 800, height 600, interval 20, puts the cursor at 400, 300,
// releases all buttons, idles the click machines and waits for the 0xFA byte.
`default_nettype none

module ps2_mouse_packet_click_decoder_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire pmcd_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output pmcd_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import pmcd_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t qstat;
  bundle_t   front_bundle;
  bundle_t   head;
  logic      front_push;
  logic      q_pop;
  logic      accept;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CfgWidth:    cfg_nxt.disp_width     = cfg_data;
        CfgHeight:   cfg_nxt.disp_height    = cfg_data;
        CfgInterval: cfg_nxt.click_interval = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{disp_width: ResetWidth, disp_height: ResetHeight,
                 click_interval: ResetInterval};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pmcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .cfg         (cfg_r),
    .bundle_push (front_push),
    .bundle      (front_bundle)
  );

  pmcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (front_push),
    .wr_data (front_bundle),
    .pop     (q_pop),
    .head    (head),
    .status  (qstat)
  );

  pmcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("bundle queue reports full and empty at once");

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    front_push |-> (front_bundle.count != '0 && front_bundle.count <= EvCntW'(MaxEvents)))
    else $error("bundle pushed with an invalid event count");

  a_msg_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_item.msg_type <= MsgMove)
    else $error("result carries an undefined message type");

  a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !empty)
    else $error("bundle retired without a result in the output register");

endmodule

`default_nettype wire
